// ----- sv/hfn_pkg.sv -----
// Package with shared types and constants of the height field normal unit.
package hfn_pkg;

    localparam int MAP_DIM     = 256;  // cells per side of the height memory
    localparam int HEIGHT_BITS = 16;   // stored bits per height
    localparam int SQRT_BITS   = 50;   // result bits of the integer square root
    localparam int QUO_BITS    = 17;   // quotient bits before saturation

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_NORMAL = 1'b1
    } opcode_t;

    localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SAMPLE_STEP = 2'd2;

endpackage

// ----- sv/hfn_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
module hfn_sqrt
    import hfn_pkg::*;
#(
    parameter int RAD_BITS = 100
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_BITS-1:0]  radicand,
    output logic                 done,
    output logic [SQRT_BITS-1:0] root
);

    localparam int CW = $clog2(SQRT_BITS + 1);

    logic [RAD_BITS-1:0]  rem_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [SQRT_BITS-1:0] root_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RAD_BITS+1:0]  trial;
    logic [RAD_BITS+1:0]  shifted;

    // Classic restoring method: bring down two radicand bits per step.
    assign shifted = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
    assign trial   = shifted - {{(RAD_BITS+2-SQRT_BITS-2){1'b0}}, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SQRT_BITS);
                rem_reg  <= '0;
                rad_reg  <= radicand;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg <= rad_reg << 2;
                if (!trial[RAD_BITS+1])
                begin
                    rem_reg  <= trial[RAD_BITS-1:0];
                    root_reg <= {root_reg[SQRT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted[RAD_BITS-1:0];
                    root_reg <= {root_reg[SQRT_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/hfn_div.sv -----
// Restoring divider giving a saturated Q1.15 component from a magnitude and a root.
module hfn_div
    import hfn_pkg::*;
#(
    parameter int MAG_BITS = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 neg,
    input  logic [MAG_BITS-1:0]  mag,
    input  logic [SQRT_BITS-1:0] divisor,
    output logic                 done,
    output logic [15:0]          result
);

    localparam int NB = MAG_BITS + 30;
    localparam int CW = $clog2(NB + 1);
    localparam int RW = SQRT_BITS + 1;

    logic [NB-1:0]        num_reg;
    logic [RW-1:0]        rem_reg;
    logic [SQRT_BITS-1:0] div_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic                 ovf_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RW-1:0]        shifted;
    logic [RW:0]          diff;
    logic                 qbit;
    logic [15:0]          sat;

    assign shifted = {rem_reg[RW-2:0], num_reg[NB-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign qbit    = !diff[RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                num_reg  <= {mag, 30'd0};
                rem_reg  <= '0;
                div_reg  <= divisor;
                quo_reg  <= '0;
                ovf_reg  <= 1'b0;
                neg_reg  <= neg;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                rem_reg <= qbit ? diff[RW-1:0] : shifted;
                quo_reg <= {quo_reg[QUO_BITS-2:0], qbit};
                // Any bit that falls off the top means the quotient is far too big.
                if (quo_reg[QUO_BITS-1])
                begin
                    ovf_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || quo_reg > QUO_BITS'(32768))
                sat = 16'h8000;
            else
                sat = 16'(-quo_reg);
        end
        else
        begin
            if (ovf_reg || quo_reg > QUO_BITS'(32767))
                sat = 16'h7FFF;
            else
                sat = quo_reg[15:0];
        end
    end

    assign done   = done_reg;
    assign result = sat;

endmodule

// ----- sv/height_field_normal_unit.sv -----
// Top level of the height field normal unit: height memory, reader and normal math.
//
//  channel | direction | contents
//  s_axis  | in        | tdata: opcode, pos_x, pos_y, height_in
//  m_axis  | out       | tdata: normal_x, normal_y, normal_z, center_height
//  cfg     | in        | map_width, map_height, sample_step by index
//
// A write word is stored as it is taken and leaves the input ready. A normal word does
// five reads of the single-port height memory (center and four neighbors), then a
// 50-step square root and three 47-step divisions in parallel. No new word is taken
// until its result is in the output register, where it is held; a stalled output
// only blocks the next normal word once it is done. Reset clears control state
// and sets the configuration registers to their defaults; the height memory is
// not cleared and must be written before read.
module height_field_normal_unit
    import hfn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode, pos_x, pos_y, height_in, 7 zero bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // normal_x, normal_y, normal_z, center_height
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int AW   = $clog2(MAP_DIM);
    localparam int DW   = HEIGHT_BITS + 1;
    localparam int SQW  = 2 * DW + 2;
    localparam int SW   = SQW + 2;
    localparam int RADW = 2 * SQRT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_SQRT, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [2:0]  rd_cnt_reg;
    logic [AW-1:0] x_reg, y_reg;
    logic [8:0]  w_reg, h_reg;
    logic [7:0]  step_reg;
    logic [HEIGHT_BITS-1:0] hc_reg, hl_reg, hr_reg, hd_reg;
    logic [HEIGHT_BITS-1:0] mem_q_reg;
    logic [HEIGHT_BITS-1:0] hmem [MAP_DIM*MAP_DIM];
    logic [63:0] out_reg;
    logic        out_valid_reg;
    logic signed [DW-1:0] dx_reg, dz_reg;
    logic [8:0]  dy_reg;
    logic [SW-1:0] s_reg;

    logic        acc;
    logic        op;
    logic [AW-1:0] in_x, in_y;
    logic [AW-1:0] rx, ry;
    logic [9:0]  w_eff, h_eff, st_eff;
    logic [10:0] cx_lo, cx_hi, cy_lo, cy_hi;
    logic [AW-1:0] nxl, nxr, nyd, nyu;
    logic        mem_we;
    logic [2*AW-1:0] mem_addr;
    logic signed [DW-1:0] dx_next, dz_next;
    logic [DW-1:0] ax, az;
    logic        sq_start, sq_done;
    logic [SQRT_BITS-1:0] root;
    logic        dv_start;
    logic [2:0]  dv_done;
    logic [15:0] nx, ny, nz;

    assign op   = s_axis_tdata[0];
    assign in_x = AW'(s_axis_tdata[8:1]);
    assign in_y = AW'(s_axis_tdata[16:9]);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    // Effective registers: sizes saturated into range, step at least one.
    assign w_eff  = (w_reg == 9'd0) ? 10'd1 : ((32'(w_reg) > MAP_DIM) ? 10'(MAP_DIM) : 10'(w_reg));
    assign h_eff  = (h_reg == 9'd0) ? 10'd1 : ((32'(h_reg) > MAP_DIM) ? 10'(MAP_DIM) : 10'(h_reg));
    assign st_eff = (step_reg == 8'd0) ? 10'd1 : 10'(step_reg);

    // Neighbor coordinates, clamped to the map.
    assign cx_lo = 11'(x_reg) - 11'(st_eff);
    assign cx_hi = 11'(x_reg) + 11'(st_eff);
    assign cy_lo = 11'(y_reg) - 11'(st_eff);
    assign cy_hi = 11'(y_reg) + 11'(st_eff);
    assign nxl = cx_lo[10] ? '0 : ((cx_lo > 11'(w_eff) - 11'd1) ? AW'(w_eff - 10'd1) : AW'(cx_lo));
    assign nxr = (cx_hi > 11'(w_eff) - 11'd1) ? AW'(w_eff - 10'd1) : AW'(cx_hi);
    assign nyd = cy_lo[10] ? '0 : ((cy_lo > 11'(h_eff) - 11'd1) ? AW'(h_eff - 10'd1) : AW'(cy_lo));
    assign nyu = (cy_hi > 11'(h_eff) - 11'd1) ? AW'(h_eff - 10'd1) : AW'(cy_hi);

    always_comb
    begin
        rx = x_reg;
        ry = y_reg;
        case (rd_cnt_reg)
            3'd1: rx = nxl;
            3'd2: rx = nxr;
            3'd3: ry = nyd;
            3'd4: ry = nyu;
            default: ;
        endcase
    end

    assign mem_we   = acc && (op == OP_WRITE);
    assign mem_addr = mem_we ? {in_y, in_x} : {ry, rx};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hmem[mem_addr] <= HEIGHT_BITS'(s_axis_tdata[32:17]);
        end
        mem_q_reg <= hmem[mem_addr];
    end

    assign dx_next = $signed({1'b0, hl_reg}) - $signed({1'b0, hr_reg});
    assign dz_next = $signed({1'b0, hd_reg}) - $signed({1'b0, mem_q_reg});
    assign ax = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign az = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            w_reg         <= 9'd256;
            h_reg         <= 9'd256;
            step_reg      <= 8'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:   w_reg    <= cfg_data;
                    REG_MAP_HEIGHT:  h_reg    <= cfg_data;
                    REG_SAMPLE_STEP: step_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc && op == OP_NORMAL)
                    begin
                        x_reg      <= in_x;
                        y_reg      <= in_y;
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    // Data of read k arrives while read k+1 is addressed.
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    case (rd_cnt_reg)
                        3'd1: hc_reg <= mem_q_reg;
                        3'd2: hl_reg <= mem_q_reg;
                        3'd3: hr_reg <= mem_q_reg;
                        3'd4: hd_reg <= mem_q_reg;
                        3'd5:
                        begin
                            dx_reg    <= dx_next;
                            dz_reg    <= dz_next;
                            dy_reg    <= {st_eff[7:0], 1'b0};
                            state_reg <= ST_SQRT;
                        end
                        default: ;
                    endcase
                end
                ST_SQRT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (dv_done[0] && !out_valid_reg)
                    begin
                        out_reg       <= {hc_reg[15:0], nz, ny, nx};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else if (dv_done[0])
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg       <= {hc_reg[15:0], nz, ny, nx};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The sum of squares is registered in the cycle before the root is started.
    logic sq_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_go_reg <= 1'b0;
        end
        else
        begin
            sq_go_reg <= (state_reg == ST_READ) && (rd_cnt_reg == 3'd5);
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= SW'(ax * ax) + SW'(az * az) + SW'(dy_reg * dy_reg);
    end

    logic s_ready_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_ready_reg <= 1'b0;
        else
            s_ready_reg <= sq_go_reg;
    end

    assign sq_start = s_ready_reg;
    assign dv_start = sq_done;

    hfn_sqrt #(.RAD_BITS(RADW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (RADW'({s_reg, 30'd0})),
        .done     (sq_done),
        .root     (root)
    );

    hfn_div #(.MAG_BITS(DW)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .neg(dx_reg[DW-1]),
        .mag(ax), .divisor(root), .done(dv_done[0]), .result(nx)
    );
    hfn_div #(.MAG_BITS(DW)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .neg(1'b0),
        .mag(DW'(dy_reg)), .divisor(root), .done(dv_done[1]), .result(ny)
    );
    hfn_div #(.MAG_BITS(DW)) u_div_z (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .neg(dz_reg[DW-1]),
        .mag(az), .divisor(root), .done(dv_done[2]), .result(nz)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // The three dividers run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_done[0] |-> (dv_done[1] && dv_done[2]))
        else $error("dividers out of step");

    // Input is only taken while no normal word is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while busy");

    // A pending result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result lost");

endmodule

// ----- tb/hfn_checker.sv -----
// Checker for the height field normal unit: mirrors the height store and predicts each normal.
`timescale 1ns / 1ps

module hfn_checker
    import hfn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output int          errors,
    output int          waiting,
    output int          normals_checked
);

    typedef struct packed {
        logic [15:0] center;
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
    } normal_t;

    logic [15:0] heights [0:65535];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [7:0]  step_reg;

    // Small ring of predicted normals; the unit never holds more than two.
    normal_t     pending_normals [16];
    logic [3:0]  wr_ptr;
    logic [3:0]  rd_ptr;
    int          pend_count;

    function automatic int clamp_coord(int v, int lim);
        if (v < 0)
            return 0;
        if (v > lim - 1)
            return lim - 1;
        return v;
    endfunction

    // Divides one difference by the vector length and saturates into Q1.15.
    function automatic logic [15:0] to_q15(longint c, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (c < 0) ? -c : c;
        q = (mag << 30) / len;
        if (c < 0)
        begin
            if (q > 32768)
                q = 32768;
            return 16'(-q);
        end
        if (q > 32767)
            q = 32767;
        return q[15:0];
    endfunction

    function automatic normal_t predict_normal(int x, int y);
        int            w;
        int            h;
        int            st;
        longint        dx;
        longint        dy;
        longint        dz;
        logic [127:0]  n;
        logic [127:0]  t;
        logic [63:0]   r;
        normal_t       res;
        w  = (width_reg < 1) ? 1 : ((width_reg > 256) ? 256 : int'(width_reg));
        h  = (height_reg < 1) ? 1 : ((height_reg > 256) ? 256 : int'(height_reg));
        st = (step_reg < 1) ? 1 : int'(step_reg);
        dx = longint'(heights[y * 256 + clamp_coord(x - st, w)])
           - longint'(heights[y * 256 + clamp_coord(x + st, w)]);
        dy = 2 * st;
        dz = longint'(heights[clamp_coord(y - st, h) * 256 + x])
           - longint'(heights[clamp_coord(y + st, h) * 256 + x]);
        n = 128'(dx * dx + dy * dy + dz * dz) << 30;
        r = 0;
        for (int b = 48; b >= 0; b--)
        begin
            t = 128'(r | (64'd1 << b));
            if (t * t <= n)
                r = t[63:0];
        end
        if (r == 0)
            r = 1;
        res.nx = to_q15(dx, r);
        res.ny = to_q15(dy, r);
        res.nz = to_q15(dz, r);
        res.center = heights[y * 256 + x];
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        normal_t got;
        normal_t want;
        int      added;
        int      taken;
        if (!rst_n)
        begin
            width_reg       <= 9'd256;
            height_reg      <= 9'd256;
            step_reg        <= 8'd1;
            errors          <= 0;
            normals_checked <= 0;
            wr_ptr          <= '0;
            rd_ptr          <= '0;
            pend_count      <= 0;
        end
        else
        begin
            added = 0;
            taken = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:   width_reg  <= cfg_data;
                    REG_MAP_HEIGHT:  height_reg <= cfg_data;
                    REG_SAMPLE_STEP: step_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (opcode_t'(s_axis_tdata[0]) == OP_WRITE)
                begin
                    heights[s_axis_tdata[16:9] * 256 + s_axis_tdata[8:1]]
                        = s_axis_tdata[32:17];
                end
                else
                begin
                    pending_normals[wr_ptr] <= predict_normal(s_axis_tdata[8:1],
                                                              s_axis_tdata[16:9]);
                    wr_ptr <= wr_ptr + 4'd1;
                    added = 1;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                normals_checked <= normals_checked + 1;
                if (pend_count == 0)
                begin
                    if (errors < 10)
                        $display("ERROR: unexpected normal word %h", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_normals[rd_ptr];
                    rd_ptr <= rd_ptr + 4'd1;
                    taken = 1;
                    if (got != want)
                    begin
                        if (errors < 10)
                            $display({"ERROR: normal mismatch exp x=%h y=%h z=%h c=%h",
                                      " got x=%h y=%h z=%h c=%h"},
                                     want.nx, want.ny, want.nz, want.center,
                                     got.nx, got.ny, got.nz, got.center);
                        errors <= errors + 1;
                    end
                end
            end
            pend_count <= pend_count + added - taken;
        end
    end

    assign waiting = pend_count;

endmodule

// ----- tb/tb_height_field_normal_unit.sv -----
// Testbench top for the height field normal unit: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_height_field_normal_unit;
    import hfn_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode, pos_x, pos_y, height_in, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // normal_x, normal_y, normal_z, center_height
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    int errors;
    int waiting;
    int normals_checked;

    // The stimulus keeps its own record of written cells so that no normal
    // ever touches a cell that holds no defined height.
    bit written [0:65535];
    int eff_w;
    int eff_h;
    int eff_step;
    int words_sent;
    int normals_sent;
    int phases_run;
    bit no_idle;
    bit held_off;

    height_field_normal_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hfn_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .waiting         (waiting),
        .normals_checked (normals_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one; none at all while no_idle is set.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_coord(int v, int lim);
        if (v < 0)
            return 0;
        if (v > lim - 1)
            return lim - 1;
        return v;
    endfunction

    // Offers one word and holds it until the block takes it. The valid is only
    // lowered when a gap follows, so it never gets two updates in one step.
    task automatic send_word(opcode_t op, int x, int y, int h);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, 16'(h), 8'(y), 8'(x), op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        if (op == OP_WRITE)
            written[y * 256 + x] = 1'b1;
        else
            normals_sent++;
    endtask

    // Writes any cell that the normal at (x, y) will read but that has no
    // height yet, then sends the normal itself.
    task automatic send_normal(int x, int y);
        int cx [5];
        int cy [5];
        cx = '{x, clamp_coord(x - eff_step, eff_w), clamp_coord(x + eff_step, eff_w), x, x};
        cy = '{y, y, y, clamp_coord(y - eff_step, eff_h), clamp_coord(y + eff_step, eff_h)};
        for (int i = 0; i < 5; i++)
            if (!written[cy[i] * 256 + cx[i]])
                send_word(OP_WRITE, cx[i], cy[i], $urandom_range(0, 65535));
        send_word(OP_NORMAL, x, y, $urandom_range(0, 65535));
    endtask

    // Waits until every normal came back, plus the time that a late normal
    // still inside the unit would need, then writes the three registers.
    task automatic reconfigure(int w, int h, int st);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data  <= 9'(w);
        @(posedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data  <= 9'(h);
        @(posedge clk);
        cfg_index <= REG_SAMPLE_STEP;
        cfg_data  <= 9'(st);
        @(posedge clk);
        cfg_we <= 1'b0;
        // Keep the stimulus view of the saturated settings in step.
        eff_w    = (w < 1) ? 1 : ((w > 256) ? 256 : w);
        eff_h    = (h < 1) ? 1 : ((h > 256) ? 256 : h);
        eff_step = ((st & 8'hFF) < 1) ? 1 : (st & 8'hFF);
        phases_run++;
    endtask

    // A burst of random words: mostly normals at random vertices, with writes
    // that refresh heights in between.
    task automatic random_words(int count);
        int start;
        start = words_sent;
        while (words_sent - start < count)
        begin
            if ($urandom_range(0, 99) < 55)
                send_normal($urandom_range(0, 255), $urandom_range(0, 255));
            else
                send_word(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 65535));
            if ($urandom_range(0, 63) == 0)
                no_idle = ~no_idle;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off early in the run so that
    // the output register fills and the input side stalls.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && normals_checked >= 20)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int done_wait;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MAP_WIDTH;
        cfg_data      = '0;
        eff_w         = 256;
        eff_h         = 256;
        eff_step      = 1;
        no_idle       = 1'b0;
        words_sent    = 0;
        normals_sent  = 0;
        phases_run    = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: corners, extreme heights,
        // a flat patch and a steepest slope.
        send_word(OP_WRITE, 0, 0, 65535);
        send_word(OP_WRITE, 1, 0, 0);
        send_word(OP_WRITE, 0, 1, 0);
        send_normal(0, 0);
        send_word(OP_WRITE, 255, 255, 0);
        send_word(OP_WRITE, 254, 255, 65535);
        send_word(OP_WRITE, 255, 254, 65535);
        send_normal(255, 255);
        send_normal(255, 0);
        send_normal(0, 255);
        send_word(OP_WRITE, 10, 10, 500);
        send_word(OP_WRITE, 9, 10, 500);
        send_word(OP_WRITE, 11, 10, 500);
        send_word(OP_WRITE, 10, 9, 500);
        send_word(OP_WRITE, 10, 11, 500);
        send_normal(10, 10);
        send_normal(128, 77);

        // Largest step: every neighbor is clamped to a border.
        reconfigure(256, 256, 255);
        send_normal(128, 128);
        send_normal(0, 255);
        random_words(40);

        // One-cell map with a zero step: vertices outside the map still
        // use their own cell, neighbors collapse onto column and row zero.
        reconfigure(1, 1, 0);
        send_normal(0, 0);
        send_normal(200, 37);
        random_words(40);

        // Out of range sizes saturate.
        reconfigure(0, 511, 3);
        send_normal(5, 255);
        random_words(60);

        reconfigure(17, 200, 5);
        send_normal(200, 100);
        random_words(120);

        reconfigure(256, 256, 2);
        random_words(200);

        for (int p = 0; p < 3; p++)
        begin
            reconfigure($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255));
            random_words(80);
        end

        s_axis_tvalid <= 1'b0;
        done_wait = 0;
        while (waiting != 0 && done_wait < 200000)
        begin
            @(posedge clk);
            done_wait++;
        end
        repeat (300) @(posedge clk);

        $display("Covered %0d input words (%0d normals) over %0d register settings.",
                 words_sent, normals_sent, phases_run);
        $display("Compared %0d normal words, %0d mismatches, %0d left outstanding.",
                 normals_checked, errors, waiting);
        if (errors == 0 && waiting == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
